>>> sv/wfdd_pkg.sv
// Package for the waypoint follower: opcodes, sequencer states, constants.
// Used by all modules of the block; depends on nothing.
package wfdd_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_APPEND  = 3'd1,
    OP_START   = 3'd2,
    OP_STOP    = 3'd3,
    OP_PROCEED = 3'd4,
    OP_POSE    = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    REG_MAX_SPEED = 2'd0,
    REG_REACH_TOL = 2'd1,
    REG_ROT_LIMIT = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIST,
    ST_CHECK,
    ST_READ2,
    ST_LOAD,
    ST_PREP,
    ST_ROT,
    ST_ANGLE,
    ST_WRAP,
    ST_CLAMP,
    ST_TRANS,
    ST_OUT
  } state_t;

  localparam int ZW = 22;
  localparam logic signed [ZW-1:0] ANG_HALF_PI_Q16 = 22'sd102944;
  localparam logic signed [17:0] PI_Q12     = 18'sd12868;
  localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

  // arctangent of 2^-i in Q.16
  function automatic logic [15:0] atan_q16(input logic [4:0] i);
    case (i)
      5'd0:  atan_q16 = 16'd51472;
      5'd1:  atan_q16 = 16'd30386;
      5'd2:  atan_q16 = 16'd16055;
      5'd3:  atan_q16 = 16'd8150;
      5'd4:  atan_q16 = 16'd4091;
      5'd5:  atan_q16 = 16'd2047;
      5'd6:  atan_q16 = 16'd1024;
      5'd7:  atan_q16 = 16'd512;
      5'd8:  atan_q16 = 16'd256;
      5'd9:  atan_q16 = 16'd128;
      5'd10: atan_q16 = 16'd64;
      5'd11: atan_q16 = 16'd32;
      5'd12: atan_q16 = 16'd16;
      5'd13: atan_q16 = 16'd8;
      5'd14: atan_q16 = 16'd4;
      5'd15: atan_q16 = 16'd2;
      5'd16: atan_q16 = 16'd1;
      default: atan_q16 = 16'd0;
    endcase
  endfunction

endpackage

>>> sv/waypoint_follow_diff_drive_top.sv
// Top level of the differential-drive waypoint follower.
// Depends on wfdd_pkg and wfdd_cordic.
//
// Channels: in_valid/in_ready carry one command transaction (opcode, pos_x,
// pos_y, heading, waypoint_speed); out_valid/out_ready return one result
// transaction per command (right_speed, left_speed, is_running, table_full).
// cfg_valid/cfg_ready write max_speed (0), reach_tolerance (1) and
// rotation_limit (2); cfg_ready is always high.
// Sequencing: table and run-control commands, and a pose while stopped, go
// straight to the result after acceptance; a pose that finds the table
// exhausted passes through the table read first. A pose update while running
// also reads and loads the next waypoint when the current one is reached;
// the CORDIC unit finds the bearing, doing one micro-rotation per cycle,
// and table read, distance, wrap, clamp and wheel-sum
// steps go through one shared multiplier/adder sequence. One command is in
// work at a time; in_ready is low from acceptance until the result is
// taken.
// Reset clears the table count, index, running flag, wheel speeds and
// registers to their defaults; the waypoint memory itself is not cleared.
// When the receiver stalls, the result is held and no new command is taken.
module waypoint_follow_diff_drive_top #(
  parameter int TABLE_DEPTH  = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         opcode,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic signed [15:0] waypoint_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] right_speed,
  output logic signed [15:0] left_speed,
  output logic               is_running,
  output logic               table_full,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CNTW = $clog2(TABLE_DEPTH + 1);

  // waypoint memory
  logic [47:0] mem [TABLE_DEPTH];
  logic [47:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [CNTW-1:0] count, index;
  logic running;
  logic [14:0] max_speed, reach_tol, rot_limit;

  wfdd_pkg::state_t state, state_next;

  logic [2:0] op;
  logic signed [15:0] px, py, hd;
  logic signed [16:0] dx, dy;
  logic [33:0] d2, tol2;
  logic signed [15:0] wspd;
  logic signed [17:0] delta, rot;
  logic signed [17:0] tra;
  logic full_flag;

  // shared multiplier
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic cs_start, cs_done;
  logic signed [17:0] bearing;

  wfdd_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cs_start), .dx(dx), .dy(dy),
    .done(cs_done), .angle(bearing)
  );

  assign in_ready  = (state == wfdd_pkg::ST_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign is_running = running;
  assign rd_addr = index[AW-1:0];

  logic end_of_table;
  assign end_of_table = index >= count;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && opcode == wfdd_pkg::OP_APPEND &&
        count < CNTW'(TABLE_DEPTH))
      mem[count[AW-1:0]] <= {pos_x, pos_y, waypoint_speed};
    rd_data <= mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_speed <= 15'd2048;
      reach_tol <= 15'd82;
      rot_limit <= 15'd2048;
    end else if (cfg_valid) begin
      case (cfg_index)
        wfdd_pkg::REG_MAX_SPEED: max_speed <= cfg_data;
        wfdd_pkg::REG_REACH_TOL: reach_tol <= cfg_data;
        wfdd_pkg::REG_ROT_LIMIT: rot_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= wfdd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    cs_start = 1'b0;
    mul_a = dx;
    mul_b = dx;
    case (state)
      wfdd_pkg::ST_IDLE:
        if (in_valid && in_ready)
          state_next = (opcode == wfdd_pkg::OP_POSE && running) ?
                       wfdd_pkg::ST_READ : wfdd_pkg::ST_OUT;
      wfdd_pkg::ST_READ:
        state_next = end_of_table ? wfdd_pkg::ST_OUT : wfdd_pkg::ST_DIST;
      wfdd_pkg::ST_DIST: begin
        mul_a = 17'(reach_tol); mul_b = 17'(reach_tol);
        state_next = wfdd_pkg::ST_CHECK;
      end
      wfdd_pkg::ST_CHECK: begin
        mul_a = dx; mul_b = dx;
        state_next = wfdd_pkg::ST_PREP;
      end
      wfdd_pkg::ST_PREP: begin
        mul_a = dy; mul_b = dy;
        if (d2 + 34'(mul_p) < tol2)
          state_next = wfdd_pkg::ST_READ2;
        else
          state_next = wfdd_pkg::ST_ROT;
      end
      wfdd_pkg::ST_READ2:
        state_next = end_of_table ? wfdd_pkg::ST_OUT : wfdd_pkg::ST_LOAD;
      wfdd_pkg::ST_LOAD:
        state_next = wfdd_pkg::ST_ROT;
      wfdd_pkg::ST_ROT: begin
        cs_start = 1'b1;
        state_next = wfdd_pkg::ST_ANGLE;
      end
      wfdd_pkg::ST_ANGLE:
        if (cs_done) state_next = wfdd_pkg::ST_WRAP;
      wfdd_pkg::ST_WRAP:
        state_next = wfdd_pkg::ST_CLAMP;
      wfdd_pkg::ST_CLAMP:
        state_next = wfdd_pkg::ST_TRANS;
      wfdd_pkg::ST_TRANS:
        state_next = wfdd_pkg::ST_OUT;
      wfdd_pkg::ST_OUT:
        state_next = wfdd_pkg::ST_IDLE;
      default: state_next = wfdd_pkg::ST_IDLE;
    endcase
  end

  logic signed [17:0] ms;
  logic signed [17:0] sum_r, sum_l;
  logic same_sign;
  assign ms = 18'(max_speed);
  assign same_sign = (tra > 0 && rot > 0) || (tra < 0 && rot < 0);
  assign sum_r = tra + rot;
  assign sum_l = tra - rot;

  // datapath and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      index <= '0;
      running <= 1'b0;
      right_speed <= '0;
      left_speed <= '0;
      out_valid <= 1'b0;
      table_full <= 1'b0;
      full_flag <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        wfdd_pkg::ST_IDLE:
          if (in_valid && in_ready) begin
            op <= opcode; px <= pos_x; py <= pos_y; hd <= heading;
            full_flag <= 1'b0;
            case (opcode)
              wfdd_pkg::OP_CLEAR: begin count <= '0; index <= '0; end
              wfdd_pkg::OP_APPEND:
                if (count < CNTW'(TABLE_DEPTH)) count <= count + 1'b1;
                else full_flag <= 1'b1;
              wfdd_pkg::OP_START: begin index <= '0; running <= 1'b1; end
              wfdd_pkg::OP_STOP: running <= 1'b0;
              wfdd_pkg::OP_PROCEED: running <= 1'b1;
              default: ;
            endcase
          end
        wfdd_pkg::ST_READ, wfdd_pkg::ST_READ2:
          if (end_of_table) begin
            running <= 1'b0; right_speed <= '0; left_speed <= '0;
          end
        wfdd_pkg::ST_DIST: begin
          dx <= 17'(signed'(rd_data[47:32])) - 17'(px);
          dy <= 17'(signed'(rd_data[31:16])) - 17'(py);
          wspd <= signed'(rd_data[15:0]);
          tol2 <= 34'(mul_p);
        end
        wfdd_pkg::ST_CHECK: d2 <= 34'(mul_p);
        wfdd_pkg::ST_PREP:
          if (state_next == wfdd_pkg::ST_READ2) index <= index + 1'b1;
        // load the next waypoint after an advance
        wfdd_pkg::ST_LOAD: begin
          dx <= 17'(signed'(rd_data[47:32])) - 17'(px);
          dy <= 17'(signed'(rd_data[31:16])) - 17'(py);
          wspd <= signed'(rd_data[15:0]);
        end
        wfdd_pkg::ST_WRAP: begin
          delta <= bearing - 18'(hd);
        end
        wfdd_pkg::ST_CLAMP: begin
          logic signed [17:0] dw;
          logic signed [18:0] r2, lim;
          lim = signed'(19'(rot_limit));
          dw = delta;
          // fold into (-pi, pi]; the error is at most two turns out
          if (dw > wfdd_pkg::PI_Q12) dw = dw - wfdd_pkg::TWO_PI_Q12;
          else if (dw <= -wfdd_pkg::PI_Q12) dw = dw + wfdd_pkg::TWO_PI_Q12;
          if (dw > wfdd_pkg::PI_Q12) dw = dw - wfdd_pkg::TWO_PI_Q12;
          else if (dw <= -wfdd_pkg::PI_Q12) dw = dw + wfdd_pkg::TWO_PI_Q12;
          r2 = 19'(dw) <<< 1;
          if (r2 > lim) rot <= 18'(lim);
          else if (r2 < -lim) rot <= 18'(-lim);
          else rot <= 18'(r2);
          tra <= 18'(wspd);
        end
        wfdd_pkg::ST_TRANS: begin
          if (same_sign) begin
            if (sum_r > ms) tra <= ms - rot;
            else if (sum_r < -ms) tra <= -ms - rot;
          end else begin
            if (sum_l > ms) tra <= ms + rot;
            else if (sum_l < -ms) tra <= -ms + rot;
          end
        end
        wfdd_pkg::ST_OUT: begin
          out_valid <= 1'b1;
          table_full <= full_flag;
          if (op == wfdd_pkg::OP_POSE && running) begin
            right_speed <= (sum_r > 18'sd32767) ? 16'sd32767 :
                           (sum_r < -18'sd32768) ? -16'sd32768 : 16'(sum_r);
            left_speed  <= (sum_l > 18'sd32767) ? 16'sd32767 :
                           (sum_l < -18'sd32768) ? -16'sd32768 : 16'(sum_l);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/wfdd_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
// Depends on wfdd_pkg for the arctangent table and angle constants.
module wfdd_cordic #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [16:0]            dx,
  input  logic signed [16:0]            dy,
  output logic                          done,
  output logic signed [17:0]            angle
);

  localparam int XW = 33;
  localparam int CW = $clog2(STEPS + 1);

  logic signed [XW-1:0] x, y;
  logic signed [wfdd_pkg::ZW-1:0] z;
  logic [CW-1:0] step;
  logic busy;
  logic zero_vec;

  logic signed [XW-1:0] xs, ys, x_in, y_in;
  logic signed [wfdd_pkg::ZW-1:0] at, zr;

  assign x_in = XW'(dx) <<< 12;
  assign y_in = XW'(dy) <<< 12;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = wfdd_pkg::ZW'(wfdd_pkg::atan_q16(5'(step)));
  assign zr = (z + wfdd_pkg::ZW'(8)) >>> 4;
  assign angle = zero_vec ? 18'sd0 : 18'(zr);

  // pre-rotate into the right half plane, then iterate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step     <= '0;
        zero_vec <= (dx == 0) && (dy == 0);
        if (dx < 0) begin
          if (dy >= 0) begin
            x <= y_in; y <= -x_in; z <= wfdd_pkg::ANG_HALF_PI_Q16;
          end else begin
            x <= -y_in; y <= x_in; z <= -wfdd_pkg::ANG_HALF_PI_Q16;
          end
        end else begin
          x <= x_in; y <= y_in; z <= '0;
        end
      end else if (busy) begin
        if (step == CW'(STEPS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          if (y >= 0) begin
            x <= x + ys; y <= y - xs; z <= z + at;
          end else begin
            x <= x - ys; y <= y + xs; z <= z - at;
          end
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule
